// ----- rtl/sdspi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and constants of the SD card SPI-mode sector transfer
// sequencer: request actions, completion status codes, command framing bytes
// and the limit register map.
// ----------------------------------------------------------------------------
package sdspi_pkg;

   // Geometry defaults.
   localparam int SECTOR_BYTES_DEF     = 512;
   localparam int IDLE_CLOCK_BYTES_DEF = 10;

   // Limit register map (word index from the byte address).
   localparam int             CSR_ADDR_W     = 4;
   localparam logic [1:0]     REG_RESP_POLL  = 2'd0;
   localparam logic [1:0]     REG_TOKEN_POLL = 2'd1;
   localparam logic [1:0]     REG_BUSY_POLL  = 2'd2;
   localparam logic [1:0]     REG_INIT_RETRY = 2'd3;

   // Limit reset values.
   localparam logic [7:0]  RESP_POLL_RST  = 8'd19;
   localparam logic [15:0] TOKEN_POLL_RST = 16'd25000;
   localparam logic [15:0] BUSY_POLL_RST  = 16'd65000;
   localparam logic [15:0] INIT_RETRY_RST = 16'd10000;

   // Request actions.
   localparam logic [1:0] ACT_EXCHANGE = 2'd0;
   localparam logic [1:0] ACT_INIT     = 2'd1;
   localparam logic [1:0] ACT_READ     = 2'd2;
   localparam logic [1:0] ACT_WRITE    = 2'd3;

   // Completion status codes.
   localparam logic [2:0] ST_OK             = 3'd0;
   localparam logic [2:0] ST_CMD_REJECTED   = 3'd1;
   localparam logic [2:0] ST_TOKEN_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_WRITE_REJECTED = 3'd3;
   localparam logic [2:0] ST_BUSY_TIMEOUT   = 3'd4;
   localparam logic [2:0] ST_NOT_IDLE       = 3'd5;
   localparam logic [2:0] ST_INIT_TIMEOUT   = 3'd6;

   // Card command indexes.
   localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
   localparam logic [5:0] CMD_SEND_OP  = 6'd1;
   localparam logic [5:0] CMD_READ_ONE = 6'd17;
   localparam logic [5:0] CMD_WRITE_ONE = 6'd24;

   // Bus bytes.
   localparam logic [7:0] BYTE_IDLE    = 8'hFF;
   localparam logic [7:0] BYTE_TOKEN   = 8'hFE;
   localparam logic [7:0] FRAME_START  = 8'h40;
   localparam logic [7:0] FRAME_CRC    = 8'h95;
   localparam logic [3:0] DRESP_ACCEPT = 4'h5;
   localparam logic [7:0] R1_IDLE      = 8'h01;
   localparam logic [7:0] R1_READY     = 8'h00;
   localparam logic [7:0] BUSY_LEVEL   = 8'h00;

   // Limit register contents handed to the sequencer.
   typedef struct packed {
      logic [7:0]  resp_poll;
      logic [15:0] token_poll;
      logic [15:0] busy_poll;
      logic [15:0] init_retry;
   } sdspi_limits_type;

endpackage
`default_nettype wire

// ----- rtl/sdspi_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_csr
// Limit registers behind a simple APB-style port. Writes land in the access
// phase; reads return the addressed register zero-extended to 32 bits.
// ----------------------------------------------------------------------------
module sdspi_csr
   import sdspi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output sdspi_limits_type           limits
);

   sdspi_limits_type limits_ff;
   logic [1:0]       reg_index;
   logic             wr_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign limits     = limits_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.resp_poll  <= RESP_POLL_RST;
         limits_ff.token_poll <= TOKEN_POLL_RST;
         limits_ff.busy_poll  <= BUSY_POLL_RST;
         limits_ff.init_retry <= INIT_RETRY_RST;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_RESP_POLL:  limits_ff.resp_poll  <= csr_pwdata[7:0];
            REG_TOKEN_POLL: limits_ff.token_poll <= csr_pwdata[15:0];
            REG_BUSY_POLL:  limits_ff.busy_poll  <= csr_pwdata[15:0];
            REG_INIT_RETRY: limits_ff.init_retry <= csr_pwdata[15:0];
            default:        limits_ff.resp_poll  <= limits_ff.resp_poll;
         endcase
      end
   end

   // Read data.
   always_comb begin
      unique case (reg_index)
         REG_RESP_POLL:  csr_prdata = {24'd0, limits_ff.resp_poll};
         REG_TOKEN_POLL: csr_prdata = {16'd0, limits_ff.token_poll};
         REG_BUSY_POLL:  csr_prdata = {16'd0, limits_ff.busy_poll};
         REG_INIT_RETRY: csr_prdata = {16'd0, limits_ff.init_retry};
         default:        csr_prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/sd_spi_sector_transfer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A request accepted at a clock edge has its response valid right after that edge,
// held in the output register until taken. Throughput: one request per cycle
// while no untaken response holds req_ready low; the sequencer state updates
// in one pass. Reset (synchronous, active high) returns the sequencer to idle,
// clears its counters and loads the limit registers with their default values.
// ----------------------------------------------------------------------------
// sd_spi_sector_transfer_top
// SD card SPI-mode sequencer for card init, single-block read and
// single-block write. Each request reports one finished byte exchange or
// starts a transaction; each response names the next exchange.
// ----------------------------------------------------------------------------
module sd_spi_sector_transfer_top
   import sdspi_pkg::*;
#(
   parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF,
   parameter int IDLE_CLOCK_BYTES = IDLE_CLOCK_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_action,
   input  wire logic [31:0]           req_sector,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic [7:0]            req_data_byte,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_chip_select_n,
   output logic                       rsp_read_valid,
   output logic [7:0]                 rsp_read_byte,
   output logic                       rsp_done_res,
   output logic [2:0]                 rsp_status,
   // Limit register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int CNT_MAX = (SECTOR_BYTES > IDLE_CLOCK_BYTES + 1) ?
                            SECTOR_BYTES : IDLE_CLOCK_BYTES + 1;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_PRECLK, PH_CMD, PH_RESP, PH_TOKPOLL, PH_RDATA, PH_RCRC,
      PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WDRESP, PH_WBUSY, PH_DES_RETRY, PH_DESEL
   } phase_type;

   sdspi_limits_type limits;

   sdspi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   // Sequencer state.
   phase_type        phase_ff,  phase_in;
   logic [2:0]       desel_status_ff, desel_status_in;
   logic [31:0]      byte_address_ff, byte_address_in;
   logic [5:0]       command_code_ff, command_code_in;
   logic [CNT_W-1:0] byte_counter_ff, byte_counter_in;
   logic [15:0]      poll_counter_ff, poll_counter_in;
   logic [15:0]      retry_counter_ff, retry_counter_in;

   // Response register.
   logic             rsp_valid_ff;
   logic             tx_valid_ff, tx_valid_in;
   logic [7:0]       tx_byte_ff, tx_byte_in;
   logic             csn_ff, csn_in;
   logic             read_valid_ff, read_valid_in;
   logic [7:0]       read_byte_ff, read_byte_in;
   logic             done_ff, done_in;
   logic [2:0]       status_ff, status_in;

   logic             accept;
   logic [CNT_W-1:0] cnt_inc;
   logic [15:0]      poll_inc;
   logic [15:0]      resp_lim, token_lim, busy_lim;

   // A zero limit acts as a limit of one.
   function automatic logic [15:0] eff_limit(input logic [15:0] lim);
      eff_limit = (lim == 16'd0) ? 16'd1 : lim;
   endfunction

   // Byte k of a command frame: start byte, four address bytes, CRC.
   function automatic logic [7:0] frame_byte(input logic [2:0]  k,
                                             input logic [5:0]  cmd,
                                             input logic [31:0] addr);
      logic [7:0] b;
      b = FRAME_CRC;
      unique case (k)
         3'd0:    b = FRAME_START | {2'b00, cmd};
         3'd1:    b = addr[31:24];
         3'd2:    b = addr[23:16];
         3'd3:    b = addr[15:8];
         3'd4:    b = addr[7:0];
         default: b = FRAME_CRC;
      endcase
      return b;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign cnt_inc   = byte_counter_ff + 1'b1;
   assign poll_inc  = poll_counter_ff + 16'd1;
   assign resp_lim  = eff_limit({8'd0, limits.resp_poll});
   assign token_lim = eff_limit(limits.token_poll);
   assign busy_lim  = eff_limit(limits.busy_poll);

   // Next state and response for the request at the input.
   always_comb begin
      phase_in         = phase_ff;
      desel_status_in  = desel_status_ff;
      byte_address_in  = byte_address_ff;
      command_code_in  = command_code_ff;
      byte_counter_in  = byte_counter_ff;
      poll_counter_in  = poll_counter_ff;
      retry_counter_in = retry_counter_ff;
      tx_valid_in      = 1'b0;
      tx_byte_in       = BYTE_IDLE;
      csn_in           = 1'b1;
      read_valid_in    = 1'b0;
      read_byte_in     = 8'd0;
      done_in          = 1'b0;
      status_in        = ST_OK;

      unique case (req_action)
         ACT_INIT: begin
            phase_in        = PH_PRECLK;
            byte_counter_in = '0;
            tx_valid_in     = 1'b1;
            csn_in          = 1'b1;
         end
         ACT_READ, ACT_WRITE: begin
            command_code_in = (req_action == ACT_READ) ? CMD_READ_ONE : CMD_WRITE_ONE;
            // Byte address of the sector, 512 bytes each.
            byte_address_in = {req_sector[22:0], 9'd0};
            phase_in        = PH_CMD;
            byte_counter_in = '0;
            tx_valid_in     = 1'b1;
            tx_byte_in      = frame_byte(3'd0, command_code_in, byte_address_in);
            csn_in          = 1'b0;
         end
         default: begin
            unique case (phase_ff)
               // Idle clocks with the card deselected, then CMD0.
               PH_PRECLK: begin
                  byte_counter_in = cnt_inc;
                  tx_valid_in     = 1'b1;
                  if (cnt_inc < CNT_W'(IDLE_CLOCK_BYTES + 1)) begin
                     csn_in = 1'b1;
                  end else begin
                     command_code_in = CMD_GO_IDLE;
                     byte_address_in = 32'd0;
                     phase_in        = PH_CMD;
                     byte_counter_in = '0;
                     tx_byte_in      = frame_byte(3'd0, CMD_GO_IDLE, 32'd0);
                     csn_in          = 1'b0;
                  end
               end
               // Remaining command frame bytes, then response polling.
               PH_CMD: begin
                  byte_counter_in = cnt_inc;
                  tx_valid_in     = 1'b1;
                  csn_in          = 1'b0;
                  if (cnt_inc < CNT_W'(6)) begin
                     tx_byte_in = frame_byte(cnt_inc[2:0], command_code_ff,
                                             byte_address_ff);
                  end else begin
                     phase_in        = PH_RESP;
                     poll_counter_in = 16'd0;
                  end
               end
               // Poll for the command response and act on it.
               PH_RESP: begin
                  poll_counter_in = poll_inc;
                  tx_valid_in     = 1'b1;
                  if (req_rx_byte != BYTE_IDLE || poll_inc >= resp_lim) begin
                     csn_in = 1'b1;
                     if (command_code_ff == CMD_GO_IDLE) begin
                        if (req_rx_byte == R1_IDLE) begin
                           retry_counter_in = limits.init_retry;
                           command_code_in  = CMD_SEND_OP;
                           phase_in         = PH_DES_RETRY;
                        end else begin
                           phase_in        = PH_DESEL;
                           desel_status_in = ST_NOT_IDLE;
                        end
                     end else if (command_code_ff == CMD_SEND_OP) begin
                        if (req_rx_byte == R1_READY) begin
                           phase_in        = PH_DESEL;
                           desel_status_in = ST_OK;
                        end else if (retry_counter_ff <= 16'd1) begin
                           phase_in        = PH_DESEL;
                           desel_status_in = ST_INIT_TIMEOUT;
                        end else begin
                           retry_counter_in = retry_counter_ff - 16'd1;
                           phase_in         = PH_DES_RETRY;
                        end
                     end else if (req_rx_byte != R1_READY) begin
                        phase_in        = PH_DESEL;
                        desel_status_in = ST_CMD_REJECTED;
                     end else if (command_code_ff == CMD_WRITE_ONE) begin
                        phase_in   = PH_WTOKEN;
                        tx_byte_in = BYTE_TOKEN;
                        csn_in     = 1'b0;
                     end else begin
                        phase_in        = PH_TOKPOLL;
                        poll_counter_in = 16'd0;
                        csn_in          = 1'b0;
                     end
                  end else begin
                     csn_in = 1'b0;
                  end
               end
               // Wait for the read data start token.
               PH_TOKPOLL: begin
                  poll_counter_in = poll_inc;
                  tx_valid_in     = 1'b1;
                  csn_in          = 1'b0;
                  if (req_rx_byte == BYTE_TOKEN) begin
                     phase_in        = PH_RDATA;
                     byte_counter_in = '0;
                  end else if (poll_inc >= token_lim) begin
                     phase_in        = PH_DESEL;
                     desel_status_in = ST_TOKEN_TIMEOUT;
                     csn_in          = 1'b1;
                  end
               end
               // Sector data bytes arrive.
               PH_RDATA: begin
                  read_valid_in   = 1'b1;
                  read_byte_in    = req_rx_byte;
                  byte_counter_in = cnt_inc;
                  if (cnt_inc >= CNT_W'(SECTOR_BYTES)) begin
                     phase_in        = PH_RCRC;
                     byte_counter_in = '0;
                  end
                  tx_valid_in = 1'b1;
                  csn_in      = 1'b0;
               end
               // Skip the two CRC bytes.
               PH_RCRC: begin
                  byte_counter_in = cnt_inc;
                  tx_valid_in     = 1'b1;
                  if (cnt_inc >= CNT_W'(2)) begin
                     phase_in        = PH_DESEL;
                     desel_status_in = ST_OK;
                     csn_in          = 1'b1;
                  end else begin
                     csn_in = 1'b0;
                  end
               end
               PH_WTOKEN: begin
                  phase_in        = PH_WDATA;
                  byte_counter_in = '0;
                  tx_valid_in     = 1'b1;
                  tx_byte_in      = req_data_byte;
                  csn_in          = 1'b0;
               end
               // Send the sector data, then the dummy CRC.
               PH_WDATA: begin
                  byte_counter_in = cnt_inc;
                  tx_valid_in     = 1'b1;
                  csn_in          = 1'b0;
                  if (cnt_inc < CNT_W'(SECTOR_BYTES)) begin
                     tx_byte_in = req_data_byte;
                  end else begin
                     phase_in        = PH_WCRC;
                     byte_counter_in = '0;
                  end
               end
               PH_WCRC: begin
                  byte_counter_in = cnt_inc;
                  if (cnt_inc >= CNT_W'(2)) begin
                     phase_in = PH_WDRESP;
                  end
                  tx_valid_in = 1'b1;
                  csn_in      = 1'b0;
               end
               // Check the data response token.
               PH_WDRESP: begin
                  tx_valid_in = 1'b1;
                  if (req_rx_byte[3:0] == DRESP_ACCEPT) begin
                     phase_in        = PH_WBUSY;
                     poll_counter_in = 16'd0;
                     csn_in          = 1'b0;
                  end else begin
                     phase_in        = PH_DESEL;
                     desel_status_in = ST_WRITE_REJECTED;
                     csn_in          = 1'b1;
                  end
               end
               // Wait while the card holds the line low.
               PH_WBUSY: begin
                  poll_counter_in = poll_inc;
                  tx_valid_in     = 1'b1;
                  if (req_rx_byte != BUSY_LEVEL) begin
                     phase_in        = PH_DESEL;
                     desel_status_in = ST_OK;
                     csn_in          = 1'b1;
                  end else if (poll_inc >= busy_lim) begin
                     phase_in        = PH_DESEL;
                     desel_status_in = ST_BUSY_TIMEOUT;
                     csn_in          = 1'b1;
                  end else begin
                     csn_in = 1'b0;
                  end
               end
               // Deselect byte done, resend the init command.
               PH_DES_RETRY: begin
                  phase_in        = PH_CMD;
                  byte_counter_in = '0;
                  tx_valid_in     = 1'b1;
                  tx_byte_in      = frame_byte(3'd0, command_code_ff, byte_address_ff);
                  csn_in          = 1'b0;
               end
               // Final deselect byte done: report completion.
               PH_DESEL: begin
                  done_in   = 1'b1;
                  status_in = desel_status_ff;
                  phase_in  = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      endcase
   end

   // State and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         desel_status_ff  <= ST_OK;
         byte_address_ff  <= 32'd0;
         command_code_ff  <= CMD_GO_IDLE;
         byte_counter_ff  <= '0;
         poll_counter_ff  <= 16'd0;
         retry_counter_ff <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            desel_status_ff  <= desel_status_in;
            byte_address_ff  <= byte_address_in;
            command_code_ff  <= command_code_in;
            byte_counter_ff  <= byte_counter_in;
            poll_counter_ff  <= poll_counter_in;
            retry_counter_ff <= retry_counter_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         tx_valid_ff   <= tx_valid_in;
         tx_byte_ff    <= tx_byte_in;
         csn_ff        <= csn_in;
         read_valid_ff <= read_valid_in;
         read_byte_ff  <= read_byte_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_chip_select_n = csn_ff;
   assign rsp_read_valid    = read_valid_ff;
   assign rsp_read_byte     = read_byte_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_status        = status_ff;

   // A finished transaction asks for no further exchange.
   a_done_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !tx_valid_ff)
      else $error("completion response also requests an exchange");

   // Read data is only reported while the card stays selected.
   a_read_selected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && read_valid_ff |-> tx_valid_ff && !csn_ff)
      else $error("read data reported outside a selected exchange");

   // No exchange means an idle, deselected bus byte.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !tx_valid_ff |-> tx_byte_ff == BYTE_IDLE && csn_ff)
      else $error("unused exchange fields not at idle values");

   // A nonzero status only comes with completion.
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> done_ff)
      else $error("status reported without completion");

   // Every accepted request leaves a response in the output register.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule
`default_nettype wire
